FILE: src/rrd_pkg.sv
// rrd_pkg: shared types and codes for the RGB24 run-length decoder.
// No dependencies; imported by every module of the decoder.
package rrd_pkg;

  // Item codes of the mode field.
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_PULL    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Parser phases.
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_ROWS   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COLS   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_COLOUR = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COUNT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

  // Width of the pixel total and the pixel countdown.
  localparam int unsigned TOTAL_W = 64;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic       byte_refused;
    logic       byte_ignored;
  } out_item_t;

  // Control from the parser to the pixel-total multiplier.
  typedef struct packed {
    logic start;
    logic clear;
  } mul_ctl_t;

endpackage

FILE: src/rrd_mul.sv
// rrd_mul: multi-cycle rows*columns multiplier with saturation to 64 bits.
// Four half-width partial products, one per cycle. Depends on rrd_pkg.
module rrd_mul
  import rrd_pkg::*;
#(
  parameter int unsigned COUNT_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mul_ctl_t           ctl,
  input  logic [COUNT_BYTES*8-1:0] op_a,
  input  logic [COUNT_BYTES*8-1:0] op_b,
  output logic               done,
  output logic [TOTAL_W-1:0] product
);

  localparam int unsigned N     = COUNT_BYTES * 8;
  localparam int unsigned H     = N / 2;
  localparam int unsigned ACC_W = 2 * N;

  logic [N-1:0]     a_r;
  logic [N-1:0]     b_r;
  logic [1:0]       step_r;
  logic             run_r;
  logic [N-1:0]     pp_r;
  logic [1:0]       pp_wt_r;
  logic             pp_vld_r;
  logic             pp_last_r;
  logic [ACC_W-1:0] acc_r;
  logic             done_r;

  logic [H-1:0]     a_half;
  logic [H-1:0]     b_half;
  logic [ACC_W-1:0] addend;

  assign a_half = step_r[1] ? a_r[N-1:H] : a_r[H-1:0];
  assign b_half = step_r[0] ? b_r[N-1:H] : b_r[H-1:0];

  always_comb begin
    case (pp_wt_r)
      2'd0:    addend = ACC_W'(pp_r);
      2'd1:    addend = ACC_W'(pp_r) << H;
      default: addend = ACC_W'(pp_r) << (2 * H);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      run_r     <= 1'b0;
      pp_vld_r  <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= 2'd0;
    end else begin
      pp_vld_r <= run_r;
      done_r   <= pp_vld_r && pp_last_r;
      if (ctl.start) begin
        a_r    <= op_a;
        b_r    <= op_b;
        step_r <= 2'd0;
        run_r  <= 1'b1;
        acc_r  <= '0;
      end else begin
        if (run_r) begin
          pp_r      <= a_half * b_half;
          pp_wt_r   <= 2'(step_r[1]) + 2'(step_r[0]);
          pp_last_r <= (step_r == 2'd3);
          step_r    <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            run_r <= 1'b0;
          end
        end
        if (pp_vld_r) begin
          acc_r <= acc_r + addend;
        end
      end
    end
  end

  generate
    if (ACC_W > TOTAL_W) begin : g_sat
      assign product = (|acc_r[ACC_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : acc_r[TOTAL_W-1:0];
    end else begin : g_nosat
      assign product = TOTAL_W'(acc_r);
    end
  endgenerate

  assign done = done_r;

endmodule

FILE: src/rrd_parse.sv
// rrd_parse: stream parser, run state and pixel emission for one item per cycle while fire is high.
// Depends on rrd_pkg; drives the rrd_mul multiplier.
module rrd_parse
  import rrd_pkg::*;
#(
  parameter int unsigned COUNT_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  in_item_t           item,
  input  logic               pl_done,
  input  logic [TOTAL_W-1:0] pl_product,
  output out_item_t          res,
  output mul_ctl_t           mul_ctl,
  output logic [COUNT_BYTES*8-1:0] mul_a,
  output logic [COUNT_BYTES*8-1:0] mul_b
);

  localparam int unsigned N     = COUNT_BYTES * 8;
  localparam int unsigned POS_W = $clog2(COUNT_BYTES);
  localparam logic [POS_W-1:0] WORD_LAST   = POS_W'(COUNT_BYTES - 1);
  localparam logic [POS_W-1:0] COLOUR_LAST = POS_W'(2);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [N-1:0]       asm_r, asm_nxt;
  logic [N-1:0]       row_r, row_nxt;
  logic [N-1:0]       run_rem_r, run_rem_nxt;
  logic [23:0]        colour_r, colour_nxt;
  logic [TOTAL_W-1:0] left_r, left_nxt;

  logic [N-1:0] asm_shift;
  logic         asm_pos;
  logic         row_pos;

  assign asm_shift = {item.data_byte, asm_r[N-1:8]};
  // Positive: sign bit clear and not zero.
  assign asm_pos   = !asm_shift[N-1] && (asm_shift != '0);
  assign row_pos   = !row_r[N-1] && (row_r != '0);
  assign mul_a     = row_r;
  assign mul_b     = asm_shift;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    asm_nxt     = asm_r;
    row_nxt     = row_r;
    run_rem_nxt = run_rem_r;
    colour_nxt  = colour_r;
    left_nxt    = left_r;
    res         = '0;
    mul_ctl     = '0;

    // Load the pixel total once the multiplier finishes.
    if (pl_done) begin
      left_nxt = pl_product;
    end

    if (fire) begin
      case (item.mode)
        MODE_RESTART: begin
          phase_nxt   = PH_ROWS;
          pos_nxt     = '0;
          asm_nxt     = '0;
          row_nxt     = '0;
          run_rem_nxt = '0;
          colour_nxt  = '0;
          left_nxt    = '0;
          mul_ctl.clear = 1'b1;
        end
        MODE_PULL: begin
          if (phase_r != PH_DONE && run_rem_r != '0) begin
            res.pixel_valid = 1'b1;
            res.red         = colour_r[23:16];
            res.green       = colour_r[15:8];
            res.blue        = colour_r[7:0];
            run_rem_nxt     = run_rem_r - N'(1);
            left_nxt        = left_r - TOTAL_W'(1);
            if (left_r == TOTAL_W'(1)) begin
              res.last_pixel = 1'b1;
              run_rem_nxt    = '0;
              phase_nxt      = PH_DONE;
            end
          end
        end
        MODE_BYTE: begin
          if (phase_r == PH_DONE) begin
            res.byte_ignored = 1'b1;
          end else if (run_rem_r != '0) begin
            res.byte_refused = 1'b1;
          end else begin
            case (phase_r)
              PH_ROWS, PH_COLS: begin
                asm_nxt = asm_shift;
                pos_nxt = pos_r + POS_W'(1);
                if (pos_r == WORD_LAST) begin
                  pos_nxt = '0;
                  if (phase_r == PH_ROWS) begin
                    row_nxt   = asm_shift;
                    phase_nxt = PH_COLS;
                  end else begin
                    mul_ctl.start = row_pos && asm_pos;
                    phase_nxt     = (row_pos && asm_pos) ? PH_COLOUR : PH_DONE;
                  end
                end
              end
              PH_COLOUR: begin
                colour_nxt = {colour_r[15:0], item.data_byte};
                pos_nxt    = pos_r + POS_W'(1);
                if (pos_r == COLOUR_LAST) begin
                  pos_nxt   = '0;
                  phase_nxt = PH_COUNT;
                end
              end
              PH_COUNT: begin
                asm_nxt = asm_shift;
                pos_nxt = pos_r + POS_W'(1);
                if (pos_r == WORD_LAST) begin
                  pos_nxt     = '0;
                  run_rem_nxt = asm_pos ? asm_shift : '0;
                  phase_nxt   = PH_COLOUR;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ROWS;
      pos_r     <= '0;
      run_rem_r <= '0;
      left_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      run_rem_r <= run_rem_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r    <= asm_nxt;
    row_r    <= row_nxt;
    colour_r <= colour_nxt;
  end

endmodule

FILE: src/rle_rgb_run_decoder.sv
// rle_rgb_run_decoder: byte-serial run-length decoder for RGB24 images.
// Path: an input transfer passes the input register, then the result register.
// Throughput: one item per cycle while out_stall is low; every item yields exactly one result.
// The header's rows*columns product is computed in a background multiplier.
// Reset: rst_n synchronous, active low; empties both registers, parser to header.
// Depends on rrd_pkg, rrd_parse and rrd_mul.
module rle_rgb_run_decoder
  import rrd_pkg::*;
#(
  parameter int unsigned COUNT_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned N = COUNT_BYTES * 8;

  // Input register: holds one transfer until the result register can take its result.
  logic      in_vld_r;
  in_item_t  in_item_r;
  // Result register: holds the result until the downstream transfer completes.
  logic      out_vld_r;
  out_item_t out_item_r;

  logic      accept;
  logic      advance;
  out_item_t res;
  mul_ctl_t  mul_ctl;
  logic [N-1:0] mul_a;
  logic [N-1:0] mul_b;
  logic      mul_done;
  logic [TOTAL_W-1:0] mul_product;

  // Advance the held item whenever the result slot is empty or is being drained.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  // Stall upstream only when the held item cannot advance.
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
  end

  // All per-item decisions happen in the parser while the item advances.
  rrd_parse #(
    .COUNT_BYTES(COUNT_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (in_item_r),
    .pl_done    (mul_done),
    .pl_product (mul_product),
    .res        (res),
    .mul_ctl    (mul_ctl),
    .mul_a      (mul_a),
    .mul_b      (mul_b)
  );

  // The pixel total is needed only at the first pull of the first run, after at least
  // three colour bytes and COUNT_BYTES count bytes past the header, so the multiply runs behind.
  rrd_mul #(
    .COUNT_BYTES(COUNT_BYTES)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // A result reports at most one event.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot0({out_item_r.pixel_valid, out_item_r.byte_refused,
                            out_item_r.byte_ignored}))
    else $error("result carries more than one event");

  // The final pixel flag only rides on a pixel.
  a_last_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.last_pixel |-> out_item_r.pixel_valid)
    else $error("last_pixel without a pixel");

  // A held item that cannot advance stays in the input register unchanged.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_item_r))
    else $error("held item lost or changed");

endmodule
